// ===== rtl/tbc_pkg.sv =====
// shared constants, types and constant tables of the thermal bilinear colormap
package tbc_pkg;

  // geometry of the thermal frame and the screen band
  localparam int SRC_W        = 32;
  localparam int SRC_H        = 24;
  localparam int OUT_W        = 480;
  localparam int BAND_LINES   = 13;
  localparam int PACKET_BYTES = 24;

  // widths of the word fields
  localparam int INDEX_W      = 8;
  localparam int DATA_W       = 64;
  localparam int ROW_FIELD_W  = 5;
  localparam int LINE_FIELD_W = 4;
  localparam int X_FIELD_W    = 9;
  localparam int COLOR_W      = 16;
  localparam int LEVEL_W      = 8;

  // action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  // frame store layout: 8-byte words, one packet is one word in each of three banks
  localparam int WORD_BYTES   = 8;
  localparam int PACKET_WORDS = PACKET_BYTES / WORD_BYTES;
  localparam int STORE_SIZE   = SRC_W * SRC_H;
  localparam int PACKET_COUNT = STORE_SIZE / PACKET_BYTES;
  localparam int NUM_SLOTS    = (STORE_SIZE + PACKET_BYTES - 1) / PACKET_BYTES;
  localparam int SLOT_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MEM_DEPTH    = 1 << SLOT_W;
  localparam int ADDR_W       = $clog2(STORE_SIZE);
  localparam int WORD_IDX_W   = ADDR_W - 3;
  localparam int ROW_W        = $clog2(SRC_H);
  localparam int COL_W        = $clog2(SRC_W);

  // word index divided by the bank count through a reciprocal
  localparam int DIV_SH  = WORD_IDX_W + 2;
  localparam int DIV_MUL = (1 << DIV_SH) / PACKET_WORDS + 1;

  // horizontal position tx = x * TX_NUM / TX_DEN in 5.8 fixed point
  localparam int     FRAC_ONE  = 256;
  localparam int     TX_NUM    = (SRC_W - 1) * FRAC_ONE;
  localparam int     TX_DEN    = OUT_W - 1;
  localparam int     N_W       = $clog2((OUT_W - 1) * TX_NUM + 1);
  localparam int     TX_W      = $clog2(TX_NUM + 1);
  localparam longint TX_RECIP  = (longint'(1) << N_W) / TX_DEN;
  localparam int     RECIP_W   = $clog2(TX_RECIP + 1);
  localparam int     P_W       = N_W + RECIP_W;

  // interpolation arithmetic
  localparam int FY_W       = 8;
  localparam int WT_W       = 17;
  localparam int MUL_W      = WT_W + 8;
  localparam int PROD_W     = 24;
  localparam int SUM_W      = 26;
  localparam int ROUND_HALF = 32768;
  localparam int LEVEL_MAX  = 255;

  // palette constants
  localparam int PAL_HALF   = 128;
  localparam int PAL_DIV    = 127;
  localparam int PAL_B_BASE = 60;
  localparam int PAL_B_SPAN = 195;
  localparam int RED_MASK   = 'hF8;

  localparam int LINE_CODES = 1 << LINE_FIELD_W;

  typedef logic [FY_W-1:0]    fy_table_t [LINE_CODES];
  typedef logic [COLOR_W-1:0] palette_t  [LEVEL_MAX + 1];

  // vertical weight per line code, lines past the band clamp to the last one
  function automatic fy_table_t build_fy_table();
    fy_table_t tbl;
    int        l;
    for (int i = 0; i < LINE_CODES; i++) begin
      l = (i > BAND_LINES - 1) ? BAND_LINES - 1 : i;
      tbl[i] = FY_W'((l * FRAC_ONE) / BAND_LINES);
    end
    return tbl;
  endfunction

  // blue-purple-red palette as byte-swapped rgb565
  function automatic palette_t build_palette();
    palette_t          tbl;
    int                r;
    int                b;
    int                t;
    logic [COLOR_W-1:0] px;
    for (int i = 0; i <= LEVEL_MAX; i++) begin
      if (i < PAL_HALF) begin
        r = (i * LEVEL_MAX) / PAL_DIV;
        b = PAL_B_BASE + (i * PAL_B_SPAN) / PAL_DIV;
      end else begin
        t = i - PAL_HALF;
        r = LEVEL_MAX;
        b = LEVEL_MAX - (t * LEVEL_MAX) / PAL_DIV;
      end
      if (r > LEVEL_MAX) r = LEVEL_MAX;
      if (b > LEVEL_MAX) b = LEVEL_MAX;
      px = COLOR_W'(((r & RED_MASK) << 8) | (b >> 3));
      tbl[i] = {px[7:0], px[15:8]};
    end
    return tbl;
  endfunction

endpackage

// ===== rtl/tbc_if.sv =====
// request and result channel interfaces of the thermal bilinear colormap

interface tbc_req_if;
  import tbc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [INDEX_W-1:0]     packet_index;
  logic [DATA_W-1:0]      data_lo;
  logic [DATA_W-1:0]      data_mid;
  logic [DATA_W-1:0]      data_hi;
  logic [ROW_FIELD_W-1:0] band_row;
  logic [LINE_FIELD_W-1:0] band_line;
  logic [X_FIELD_W-1:0]   screen_x;

  modport source (
    output valid, action, packet_index, data_lo, data_mid, data_hi,
           band_row, band_line, screen_x,
    input  ready
  );

  modport sink (
    input  valid, action, packet_index, data_lo, data_mid, data_hi,
           band_row, band_line, screen_x,
    output ready
  );
endinterface

interface tbc_rsp_if;
  import tbc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, pixel_color, level, input ready);
  modport sink   (input valid, pixel_color, level, output ready);
endinterface

// ===== rtl/thermal_bilinear_colormap.sv =====
// thermal frame store with bilinear upscaling and heat-map palette, nine-stage pipeline
//
// req carries one word per item: action write drops a 24-byte packet into the
// 32x24 frame store (packets 32 and up are dropped), action render asks for one
// screen pixel of a band. rsp carries one word per render: the palette color and
// the interpolated level. writes give no rsp word.
// nine register stages lie between req and rsp; a render word passes through all
// of them. throughput: one word per cycle while rsp does not stall, set by the
// pipeline; the store is kept in two copies of three banks so the
// four neighbor bytes come out of single-port reads together.
// packets are written into the store at stage five, where renders read it, so
// every render sees exactly the writes taken before it.
// reset empties the pipeline and clears one valid flag per packet slot; an
// unwritten slot reads as zero, so the block takes words as soon as reset is
// released, with no clearing pass.
// when rsp stalls each stage holds its word, empty stages still fill, and
// req.ready drops only once every stage is occupied.
module thermal_bilinear_colormap (
  input  logic      clk,
  input  logic      rst,
  tbc_req_if.sink   req,
  tbc_rsp_if.source rsp
);
  import tbc_pkg::*;

  localparam fy_table_t              FY_TABLE   = build_fy_table();
  localparam palette_t               PALETTE    = build_palette();
  localparam logic [RECIP_W-1:0]     TX_RECIP_V = RECIP_W'(TX_RECIP);

  typedef struct packed {
    logic                                render;
    logic                                wr_ok;
    logic [SLOT_W-1:0]                   slot;
    logic [PACKET_WORDS-1:0][DATA_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [ROW_W-1:0] y0;
    logic [ROW_W-1:0] y1;
    logic [FY_W-1:0]  fy;
    logic [N_W-1:0]   n;
  } s1_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [ROW_W-1:0] y0;
    logic [ROW_W-1:0] y1;
    logic [FY_W-1:0]  fy;
    logic [N_W-1:0]   n;
    logic [P_W-1:0]   prod;
  } s2_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [ROW_W-1:0] y0;
    logic [ROW_W-1:0] y1;
    logic [FY_W-1:0]  fy;
    logic [N_W-1:0]   n;
    logic [TX_W-1:0]  q_est;
    logic [N_W-1:0]   qd;
  } s3_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [7:0]            fx;
    logic [FY_W-1:0]       fy;
    logic                  step;
    logic [1:0][ADDR_W-1:0] a;
  } s4_t;

  typedef struct packed {
    cmd_t                                   cmd;
    logic [1:0][PACKET_WORDS-1:0][SLOT_W-1:0] raddr;
    logic [1:0][1:0]                        m;
    logic [1:0][2:0]                        boff;
    logic                                   step;
    logic [3:0][WT_W-1:0]                   wt;
  } s5_t;

  typedef struct packed {
    logic [1:0][1:0]      m;
    logic [1:0][2:0]      boff;
    logic                 step;
    logic [3:0][WT_W-1:0] wt;
  } s6_t;

  typedef struct packed {
    logic [3:0][PROD_W-1:0] prod;
  } s7_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
  } s8_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic [LEVEL_W-1:0] level;
  } s9_t;

  // stage registers and their valid bits
  s1_t s1, s1_next;
  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4, s4_next;
  s5_t s5, s5_next;
  s6_t s6;
  s7_t s7, s7_next;
  s8_t s8, s8_next;
  s9_t s9, s9_next;
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic e1, e2, e3, e4, e5, e6, e7, e8, e9;

  // frame store: two copies (upper and lower row) of three banks
  logic [DATA_W-1:0] bank_mem [2][PACKET_WORDS][MEM_DEPTH];
  logic [MEM_DEPTH-1:0] slot_valid;
  logic [1:0][PACKET_WORDS-1:0][DATA_W-1:0] rdata;
  logic [1:0][PACKET_WORDS-1:0]             rvalid;
  logic wr_fire;

  // combinational helpers
  logic [ROW_W-1:0]     row_sat;
  logic [X_FIELD_W-1:0] x_sat;
  logic [TX_W-1:0]      q_est_c;
  logic [N_W-1:0]       rem_c;
  logic [TX_W-1:0]      tx_c;
  logic [COL_W-1:0]     x0_c;
  logic [8:0]           ifx_c;
  logic [8:0]           ify_c;
  logic [1:0][WORD_IDX_W-1:0] word_c;
  logic [1:0][WORD_IDX_W-1:0] word_q_c;
  logic [1:0][DATA_W-1:0]     word0_c;
  logic [1:0][DATA_W-1:0]     word1_c;
  logic [1:0][2*DATA_W-1:0]   pair_c;
  logic [1:0][PACKET_WORDS-1:0][DATA_W-1:0] bank_word_c;
  logic [3:0][7:0]            pix_c;
  logic [SUM_W-1:0]           sum_c;
  logic [SUM_W-17:0]          val_c;

  // per-stage load enables, bubbles close up under a stall
  assign e9 = !v9 || rsp.ready;
  assign e8 = !v8 || e9;
  assign e7 = !v7 || e8;
  assign e6 = !v6 || e7;
  assign e5 = !v5 || e6;
  assign e4 = !v4 || e5;
  assign e3 = !v3 || e4;
  assign e2 = !v2 || e3;
  assign e1 = !v1 || e2;

  assign req.ready       = e1;
  assign rsp.valid       = v9;
  assign rsp.pixel_color = s9.pixel_color;
  assign rsp.level       = s9.level;

  // stage 1: decode, clamp, vertical weight, horizontal numerator
  always_comb begin
    s1_next.cmd.render = (req.action == ACT_RENDER);
    s1_next.cmd.wr_ok  = (32'(req.packet_index) < PACKET_COUNT);
    s1_next.cmd.slot   = SLOT_W'(req.packet_index);
    s1_next.cmd.data   = {req.data_hi, req.data_mid, req.data_lo};
    if (32'(req.band_row) > SRC_H - 1) begin
      row_sat = ROW_W'(SRC_H - 1);
    end else begin
      row_sat = ROW_W'(req.band_row);
    end
    if (32'(req.screen_x) > OUT_W - 1) begin
      x_sat = X_FIELD_W'(OUT_W - 1);
    end else begin
      x_sat = req.screen_x;
    end
    s1_next.y0 = row_sat;
    if (32'(row_sat) < SRC_H - 1) begin
      s1_next.y1 = row_sat + ROW_W'(1);
    end else begin
      s1_next.y1 = row_sat;
    end
    s1_next.fy = FY_TABLE[req.band_line];
    s1_next.n  = N_W'(32'(x_sat) * TX_NUM);
  end

  // stage 2: reciprocal product for the division by the screen span
  always_comb begin
    s2_next.cmd  = s1.cmd;
    s2_next.y0   = s1.y0;
    s2_next.y1   = s1.y1;
    s2_next.fy   = s1.fy;
    s2_next.n    = s1.n;
    s2_next.prod = P_W'(s1.n) * P_W'(TX_RECIP_V);
  end

  // stage 3: quotient estimate and its back product
  always_comb begin
    q_est_c       = TX_W'(s2.prod >> N_W);
    s3_next.cmd   = s2.cmd;
    s3_next.y0    = s2.y0;
    s3_next.y1    = s2.y1;
    s3_next.fy    = s2.fy;
    s3_next.n     = s2.n;
    s3_next.q_est = q_est_c;
    s3_next.qd    = N_W'(32'(q_est_c) * TX_DEN);
  end

  // stage 4: quotient correction, column split, byte addresses of both rows
  always_comb begin
    rem_c = s3.n - s3.qd;
    tx_c  = s3.q_est + TX_W'(rem_c >= N_W'(TX_DEN));
    if (32'(tx_c >> 8) > SRC_W - 1) begin
      x0_c = COL_W'(SRC_W - 1);
    end else begin
      x0_c = COL_W'(tx_c >> 8);
    end
    s4_next.cmd  = s3.cmd;
    s4_next.fx   = tx_c[7:0];
    s4_next.fy   = s3.fy;
    s4_next.step = (32'(x0_c) < SRC_W - 1);
    s4_next.a[0] = ADDR_W'(32'(s3.y0) * SRC_W + 32'(x0_c));
    s4_next.a[1] = ADDR_W'(32'(s3.y1) * SRC_W + 32'(x0_c));
  end

  // stage 5: corner weights, bank and slot of each word to read
  always_comb begin
    ifx_c        = 9'(FRAC_ONE) - 9'(s4.fx);
    ify_c        = 9'(FRAC_ONE) - 9'(s4.fy);
    s5_next.cmd  = s4.cmd;
    s5_next.step = s4.step;
    s5_next.wt[0] = WT_W'(ifx_c) * WT_W'(ify_c);
    s5_next.wt[1] = WT_W'(s4.fx) * WT_W'(ify_c);
    s5_next.wt[2] = WT_W'(ifx_c) * WT_W'(s4.fy);
    s5_next.wt[3] = WT_W'(s4.fx) * WT_W'(s4.fy);
    for (int c = 0; c < 2; c++) begin
      word_c[c]   = s4.a[c][ADDR_W-1:3];
      word_q_c[c] = WORD_IDX_W'((32'(word_c[c]) * DIV_MUL) >> DIV_SH);
      s5_next.m[c]    = 2'(32'(word_c[c]) - PACKET_WORDS * 32'(word_q_c[c]));
      s5_next.boff[c] = s4.a[c][2:0];
      // the word after the first sits one slot up when the first is in the last bank
      for (int j = 0; j < PACKET_WORDS; j++) begin
        if (s5_next.m[c] == 2'(PACKET_WORDS - 1) && j != PACKET_WORDS - 1) begin
          s5_next.raddr[c][j] = SLOT_W'(word_q_c[c]) + SLOT_W'(1);
        end else begin
          s5_next.raddr[c][j] = SLOT_W'(word_q_c[c]);
        end
      end
    end
  end

  // packet write lands where renders read, keeping item order
  assign wr_fire = v5 && !s5.cmd.render && s5.cmd.wr_ok && e6;

  // frame store banks: packet write and registered reads
  always_ff @(posedge clk) begin
    for (int c = 0; c < 2; c++) begin
      for (int j = 0; j < PACKET_WORDS; j++) begin
        if (wr_fire) begin
          bank_mem[c][j][s5.cmd.slot] <= s5.cmd.data[j];
        end
        if (e6) begin
          rdata[c][j]  <= bank_mem[c][j][s5.raddr[c][j]];
          rvalid[c][j] <= slot_valid[s5.raddr[c][j]];
        end
      end
    end
  end

  // one written flag per packet slot
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_fire) begin
      slot_valid[s5.cmd.slot] <= 1'b1;
    end
  end

  // stage 7: pick the four neighbor bytes and weight them
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      for (int j = 0; j < PACKET_WORDS; j++) begin
        bank_word_c[c][j] = rvalid[c][j] ? rdata[c][j] : '0;
      end
      case (s6.m[c])
        2'd0: begin
          word0_c[c] = bank_word_c[c][0];
          word1_c[c] = bank_word_c[c][1];
        end
        2'd1: begin
          word0_c[c] = bank_word_c[c][1];
          word1_c[c] = bank_word_c[c][2];
        end
        2'd2: begin
          word0_c[c] = bank_word_c[c][2];
          word1_c[c] = bank_word_c[c][0];
        end
        default: begin
          word0_c[c] = '0;
          word1_c[c] = '0;
        end
      endcase
      pair_c[c]  = {word1_c[c], word0_c[c]};
      pix_c[2*c] = word0_c[c][8*s6.boff[c] +: 8];
      if (s6.step) begin
        pix_c[2*c+1] = pair_c[c][8*(4'(s6.boff[c]) + 4'd1) +: 8];
      end else begin
        pix_c[2*c+1] = pix_c[2*c];
      end
    end
    for (int k = 0; k < 4; k++) begin
      s7_next.prod[k] = PROD_W'(MUL_W'(pix_c[k]) * MUL_W'(s6.wt[k]));
    end
  end

  // stage 8: sum, round, saturate
  always_comb begin
    sum_c = SUM_W'(s7.prod[0]) + SUM_W'(s7.prod[1]) + SUM_W'(s7.prod[2])
          + SUM_W'(s7.prod[3]) + SUM_W'(ROUND_HALF);
    val_c = sum_c[SUM_W-1:16];
    if (32'(val_c) > LEVEL_MAX) begin
      s8_next.level = LEVEL_W'(LEVEL_MAX);
    end else begin
      s8_next.level = LEVEL_W'(val_c);
    end
  end

  // stage 9: palette lookup
  always_comb begin
    s9_next.pixel_color = PALETTE[s8.level];
    s9_next.level       = s8.level;
  end

  // valid bits, writes leave the pipe after stage 5
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      if (e1) v1 <= req.valid;
      if (e2) v2 <= v1;
      if (e3) v3 <= v2;
      if (e4) v4 <= v3;
      if (e5) v5 <= v4;
      if (e6) v6 <= v5 && s5.cmd.render;
      if (e7) v7 <= v6;
      if (e8) v8 <= v7;
      if (e9) v9 <= v8;
    end
  end

  // stage payload registers
  always_ff @(posedge clk) begin
    if (e1) s1 <= s1_next;
    if (e2) s2 <= s2_next;
    if (e3) s3 <= s3_next;
    if (e4) s4 <= s4_next;
    if (e5) s5 <= s5_next;
    if (e6) begin
      s6.m    <= s5.m;
      s6.boff <= s5.boff;
      s6.step <= s5.step;
      s6.wt   <= s5.wt;
    end
    if (e7) s7 <= s7_next;
    if (e8) s8 <= s8_next;
    if (e9) s9 <= s9_next;
  end

endmodule
